// ----- src/jbst_pkg.sv -----
package jbst_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 5;
  localparam int SEQ_W   = 16;
  localparam int STAMP_W = 32;
  localparam int LEN_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int SEL_W   = 4;
  localparam int KIND_W  = 3;
  localparam int DATA_W  = 16;
  localparam int ENTRY_W = SEQ_W + STAMP_W + LEN_W;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_BUFFER   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_LOOKUP  = 3'd1,
    KIND_OLDEST  = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_FLUSH   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EVICTED = 3'd1,
    ST_DUP     = 3'd2,
    ST_DROP    = 3'd3,
    ST_HIT     = 3'd4,
    ST_MISS    = 3'd5,
    ST_FLUSHED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic fetch;
    logic finish;
  } jbst_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_end;
    logic out_free;
  } jbst_sts_t;

endpackage

// ----- src/jitter_buffer_slot_table_core.sv -----
// Packet slot table for a jitter buffer.
// Input channel (in_valid / in_stall) carries one operation per item: insert,
// lookup by sequence, oldest query, release by slot index or flush. Output
// channel (out_valid / out_stall) returns exactly one result item per input.
// Configuration (cfg_we, cfg_index, cfg_data) sets capacity in use and the
// per-slot buffer size; write it only while the table is idle.
// Insert, lookup and oldest query walk the slots in use through the single
// read port of the slot memory, one slot per cycle, then drain the last
// read, fetch the chosen slot and load the result. Release, flush and
// unknown kinds skip the walk and go straight to the fetch.
// One item is worked at a time; in_stall is high from acceptance until the
// result has been loaded into the output register.
// Reset (rst, synchronous) empties every slot, clears the count and sets
// capacity to the built depth and buffer size to zero (no clipping).
// While out_stall is high the result is held; the next item may be accepted
// and worked, but its result waits until the held one is taken.
module jitter_buffer_slot_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jbst_pkg::KIND_W-1:0]   kind,
  input  logic [jbst_pkg::SEQ_W-1:0]    seq,
  input  logic [jbst_pkg::SEQ_W-1:0]    playhead,
  input  logic [jbst_pkg::STAMP_W-1:0]  stamp,
  input  logic [jbst_pkg::LEN_W-1:0]    pkt_length,
  input  logic [jbst_pkg::SEL_W-1:0]    slot_sel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [jbst_pkg::SLOT_W-1:0]   slot,
  output logic                          evicted_valid,
  output logic [jbst_pkg::SEQ_W-1:0]    evicted_seq,
  output logic [jbst_pkg::SEQ_W-1:0]    entry_seq,
  output logic [jbst_pkg::STAMP_W-1:0]  entry_stamp,
  output logic [jbst_pkg::LEN_W-1:0]    entry_length,
  output logic [jbst_pkg::LEN_W-1:0]    copy_length,
  output logic [jbst_pkg::CNT_W-1:0]    occupancy,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [jbst_pkg::DATA_W-1:0]   cfg_data
);

  jbst_pkg::jbst_cmd_t cmd;
  jbst_pkg::jbst_sts_t sts;

  jbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  jbst_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (kind),
    .seq           (seq),
    .playhead      (playhead),
    .stamp         (stamp),
    .pkt_length    (pkt_length),
    .slot_sel      (slot_sel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_seq   (evicted_seq),
    .entry_seq     (entry_seq),
    .entry_stamp   (entry_stamp),
    .entry_length  (entry_length),
    .copy_length   (copy_length),
    .occupancy     (occupancy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

endmodule

// ----- src/jbst_ctrl.sv -----
module jbst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  jbst_pkg::jbst_sts_t sts,
  output jbst_pkg::jbst_cmd_t cmd
);

  jbst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jbst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = (state != jbst_pkg::S_IDLE);
    case (state)
      jbst_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.needs_scan ? jbst_pkg::S_SCAN : jbst_pkg::S_FETCH;
        end
      end
      jbst_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_end) begin
          state_next = jbst_pkg::S_DRAIN;
        end
      end
      jbst_pkg::S_DRAIN: begin
        state_next = jbst_pkg::S_FETCH;
      end
      jbst_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = jbst_pkg::S_FINISH;
      end
      jbst_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = jbst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = jbst_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> $past(state) == jbst_pkg::S_IDLE || $past(state) == jbst_pkg::S_SCAN)
    else $error("scan read outside a scan");
  a_finish_after_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> $past(state) == jbst_pkg::S_FETCH || $past(state) == jbst_pkg::S_FINISH)
    else $error("finish without a fetch");
  a_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state != jbst_pkg::S_IDLE)
    else $error("item accepted but controller stayed idle");
`endif

endmodule

// ----- src/jbst_dp.sv -----
module jbst_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  jbst_pkg::jbst_cmd_t               cmd,
  output jbst_pkg::jbst_sts_t               sts,
  input  logic [jbst_pkg::KIND_W-1:0]       kind,
  input  logic [jbst_pkg::SEQ_W-1:0]        seq,
  input  logic [jbst_pkg::SEQ_W-1:0]        playhead,
  input  logic [jbst_pkg::STAMP_W-1:0]      stamp,
  input  logic [jbst_pkg::LEN_W-1:0]        pkt_length,
  input  logic [jbst_pkg::SEL_W-1:0]        slot_sel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [jbst_pkg::SLOT_W-1:0]       slot,
  output logic                              evicted_valid,
  output logic [jbst_pkg::SEQ_W-1:0]        evicted_seq,
  output logic [jbst_pkg::SEQ_W-1:0]        entry_seq,
  output logic [jbst_pkg::STAMP_W-1:0]      entry_stamp,
  output logic [jbst_pkg::LEN_W-1:0]        entry_length,
  output logic [jbst_pkg::LEN_W-1:0]        copy_length,
  output logic [jbst_pkg::CNT_W-1:0]        occupancy,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [jbst_pkg::DATA_W-1:0]       cfg_data
);

  localparam int IW = jbst_pkg::IDX_W;
  localparam int CW = jbst_pkg::CNT_W;

  logic [jbst_pkg::ENTRY_W-1:0] mem [jbst_pkg::DEPTH];
  logic [jbst_pkg::ENTRY_W-1:0] rd_word;

  logic [jbst_pkg::DEPTH-1:0]   valid, valid_next;
  logic [CW-1:0]                used, used_next;
  logic [jbst_pkg::CAP_W-1:0]   capacity;
  logic [jbst_pkg::LEN_W-1:0]   buf_bytes;

  logic [jbst_pkg::KIND_W-1:0]  kind_q;
  logic [jbst_pkg::SEQ_W-1:0]   seq_q, ph_q;
  logic [jbst_pkg::STAMP_W-1:0] stamp_q;
  logic [jbst_pkg::LEN_W-1:0]   len_q;
  logic [jbst_pkg::SEL_W-1:0]   sel_q;

  logic [CW-1:0]                cnt, cap_eff;
  logic                         pend;
  logic [IW-1:0]                pend_idx;
  logic                         dup_found, pos_found, any_found, free_found;
  logic [IW-1:0]                dup_idx, pos_idx, any_idx, free_idx;
  logic [jbst_pkg::SEQ_W-2:0]   pos_dist;
  logic [jbst_pkg::SEQ_W-1:0]   any_dist;

  logic [jbst_pkg::SEQ_W-1:0]   e_seq, seq_gap;
  logic [jbst_pkg::STAMP_W-1:0] e_stamp;
  logic [jbst_pkg::LEN_W-1:0]   e_len, clip_len;
  logic [IW-1:0]                victim_idx, ins_slot, fetch_idx, rd_addr, sel_idx;
  logic                         full, evict, ins_ok, rel_ok, wr_en;

  jbst_pkg::status_t            res_status, status_q;
  logic [jbst_pkg::SLOT_W-1:0]  res_slot;
  logic                         res_ev;
  logic [jbst_pkg::SEQ_W-1:0]   res_evseq, res_eseq;
  logic [jbst_pkg::STAMP_W-1:0] res_estamp;
  logic [jbst_pkg::LEN_W-1:0]   res_elen, res_copy;

  assign e_seq   = rd_word[jbst_pkg::ENTRY_W-1 -: jbst_pkg::SEQ_W];
  assign e_stamp = rd_word[jbst_pkg::LEN_W +: jbst_pkg::STAMP_W];
  assign e_len   = rd_word[jbst_pkg::LEN_W-1:0];
  assign seq_gap = e_seq - ph_q;
  assign sel_idx = IW'(sel_q);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (int'(capacity) > jbst_pkg::DEPTH) begin
      cap_eff = CW'(jbst_pkg::DEPTH);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  assign sts.needs_scan = (kind == jbst_pkg::KIND_INSERT) || (kind == jbst_pkg::KIND_LOOKUP) ||
                          (kind == jbst_pkg::KIND_OLDEST);
  assign sts.scan_end   = (cnt == cap_eff - CW'(1));
  assign sts.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= jbst_pkg::CAP_W'(jbst_pkg::DEPTH);
      buf_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        jbst_pkg::REG_CAPACITY: capacity  <= cfg_data[jbst_pkg::CAP_W-1:0];
        jbst_pkg::REG_BUFFER:   buf_bytes <= cfg_data[jbst_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      seq_q   <= seq;
      ph_q    <= playhead;
      stamp_q <= stamp;
      len_q   <= pkt_length;
      sel_q   <= slot_sel;
    end
  end

  // scan: one slot read per cycle, judged the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend       <= 1'b0;
      dup_found  <= 1'b0;
      pos_found  <= 1'b0;
      any_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      cnt        <= '0;
      pend       <= 1'b0;
      dup_found  <= 1'b0;
      pos_found  <= 1'b0;
      any_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      pend <= cmd.scan_rd;
      if (cmd.scan_rd) begin
        cnt <= cnt + CW'(1);
      end
      if (pend) begin
        if (valid[pend_idx]) begin
          if (!dup_found && e_seq == seq_q) begin
            dup_found <= 1'b1;
          end
          if (!seq_gap[jbst_pkg::SEQ_W-1] &&
              (!pos_found || seq_gap[jbst_pkg::SEQ_W-2:0] < pos_dist)) begin
            pos_found <= 1'b1;
          end
          if (!any_found || $signed(seq_gap) < $signed(any_dist)) begin
            any_found <= 1'b1;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      pend_idx <= cnt[IW-1:0];
    end
    if (pend && valid[pend_idx]) begin
      if (!dup_found && e_seq == seq_q) begin
        dup_idx <= pend_idx;
      end
      if (!seq_gap[jbst_pkg::SEQ_W-1] &&
          (!pos_found || seq_gap[jbst_pkg::SEQ_W-2:0] < pos_dist)) begin
        pos_idx  <= pend_idx;
        pos_dist <= seq_gap[jbst_pkg::SEQ_W-2:0];
      end
      if (!any_found || $signed(seq_gap) < $signed(any_dist)) begin
        any_idx  <= pend_idx;
        any_dist <= seq_gap;
      end
    end
    if (pend && !valid[pend_idx] && !free_found) begin
      free_idx <= pend_idx;
    end
  end

  assign victim_idx = pos_found ? pos_idx : any_idx;
  assign full       = (used >= cap_eff);
  assign evict      = full && any_found;
  assign rel_ok     = (int'(sel_q) < jbst_pkg::DEPTH) && valid[sel_idx];
  assign clip_len   = (buf_bytes != '0 && len_q > buf_bytes) ? buf_bytes : len_q;

  always_comb begin
    if (full) begin
      ins_ok   = evict;
      ins_slot = (free_found && free_idx < victim_idx) ? free_idx : victim_idx;
    end else begin
      ins_ok   = free_found;
      ins_slot = free_idx;
    end
  end

  always_comb begin
    case (kind_q)
      jbst_pkg::KIND_INSERT: fetch_idx = dup_found ? dup_idx : victim_idx;
      jbst_pkg::KIND_LOOKUP: fetch_idx = dup_idx;
      jbst_pkg::KIND_OLDEST: fetch_idx = victim_idx;
      default:               fetch_idx = sel_idx;
    endcase
  end

  assign rd_addr = cmd.fetch ? fetch_idx : cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.fetch) begin
      rd_word <= mem[rd_addr];
    end
    if (cmd.finish && wr_en) begin
      mem[ins_slot] <= {seq_q, stamp_q, len_q};
    end
  end

  always_comb begin
    res_status = jbst_pkg::ST_MISS;
    res_slot   = '0;
    res_ev     = 1'b0;
    res_evseq  = '0;
    res_eseq   = '0;
    res_estamp = '0;
    res_elen   = '0;
    res_copy   = '0;
    valid_next = valid;
    used_next  = used;
    wr_en      = 1'b0;
    case (kind_q)
      jbst_pkg::KIND_INSERT: begin
        if (dup_found) begin
          res_status = jbst_pkg::ST_DUP;
          res_slot   = jbst_pkg::SLOT_W'(dup_idx);
          res_eseq   = e_seq;
          res_estamp = e_stamp;
          res_elen   = e_len;
        end else if (ins_ok) begin
          wr_en = 1'b1;
          if (evict) begin
            valid_next[victim_idx] = 1'b0;
          end
          valid_next[ins_slot] = 1'b1;
          used_next  = used + CW'(1) - CW'(evict);
          res_status = evict ? jbst_pkg::ST_EVICTED : jbst_pkg::ST_OK;
          res_slot   = jbst_pkg::SLOT_W'(ins_slot);
          res_ev     = evict;
          res_evseq  = evict ? e_seq : '0;
          res_copy   = clip_len;
        end else begin
          res_status = jbst_pkg::ST_DROP;
        end
      end
      jbst_pkg::KIND_LOOKUP: begin
        if (dup_found) begin
          res_status = jbst_pkg::ST_HIT;
          res_slot   = jbst_pkg::SLOT_W'(dup_idx);
          res_eseq   = e_seq;
          res_estamp = e_stamp;
          res_elen   = e_len;
        end
      end
      jbst_pkg::KIND_OLDEST: begin
        if (any_found) begin
          res_status = jbst_pkg::ST_HIT;
          res_slot   = jbst_pkg::SLOT_W'(victim_idx);
          res_eseq   = e_seq;
          res_estamp = e_stamp;
          res_elen   = e_len;
        end
      end
      jbst_pkg::KIND_RELEASE: begin
        if (rel_ok) begin
          valid_next[sel_idx] = 1'b0;
          used_next  = used - CW'(1);
          res_status = jbst_pkg::ST_HIT;
          res_slot   = jbst_pkg::SLOT_W'(sel_idx);
          res_eseq   = e_seq;
          res_estamp = e_stamp;
          res_elen   = e_len;
        end
      end
      jbst_pkg::KIND_FLUSH: begin
        valid_next = '0;
        used_next  = '0;
        res_status = jbst_pkg::ST_FLUSHED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
    end else if (cmd.finish) begin
      valid <= valid_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_q      <= res_status;
      slot          <= res_slot;
      evicted_valid <= res_ev;
      evicted_seq   <= res_evseq;
      entry_seq     <= res_eseq;
      entry_stamp   <= res_estamp;
      entry_length  <= res_elen;
      copy_length   <= res_copy;
      occupancy     <= used_next;
    end
  end

  assign status = status_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    used == CW'($countones(valid)))
    else $error("occupancy count out of step with slot valid bits");
  a_evict_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> status_q == jbst_pkg::ST_EVICTED)
    else $error("eviction reported without evicted status");
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && res_status == jbst_pkg::ST_FLUSHED) |=> used == '0 && occupancy == '0)
    else $error("flush left slots in use");
`endif

endmodule
